// ===== design/step_counter_dynamic_threshold_assert.svh =====
// ----------------------------------------------------------------------------
// step counter assertion macros
// concurrent assertion wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef STEP_COUNTER_DYNAMIC_THRESHOLD_ASSERT_SVH
`define STEP_COUNTER_DYNAMIC_THRESHOLD_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCDT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SCDT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SCDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/scdt_pkg.sv =====
// ----------------------------------------------------------------------------
// step counter package
// field widths, register indexes, reset values and shared types
// ----------------------------------------------------------------------------
package scdt_pkg;

  localparam int MAG_W      = 16;
  localparam int TIME_W     = 32;
  localparam int GAP_W      = 24;
  localparam int WLEN_W     = 10;
  localparam int LVL_W      = 16;
  localparam int COUNT_W    = 32;
  localparam int SMOOTH_W   = 19;
  localparam int THR_OUT_W  = 20;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MAG_MAX     = 65535;
  localparam int TROUGH_BASE = 32768;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_STEP_GAP    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SWING_LIMIT     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REST_THRESHOLD  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_START_THRESHOLD = 3'd4;

  // register reset values
  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST   = 10'd50;
  localparam logic [GAP_W-1:0]  MIN_STEP_GAP_RST    = 24'd600000;
  localparam logic [LVL_W-1:0]  SWING_LIMIT_RST     = 16'd1500;
  localparam logic [LVL_W-1:0]  REST_THRESHOLD_RST  = 16'd16384;
  localparam logic [LVL_W-1:0]  START_THRESHOLD_RST = 16'd32000;

  typedef struct packed {
    logic [WLEN_W-1:0] window_length;
    logic [GAP_W-1:0]  min_step_gap_us;
    logic [LVL_W-1:0]  swing_limit;
    logic [LVL_W-1:0]  rest_threshold;
    logic [LVL_W-1:0]  start_threshold;
  } cfg_t;

  // reload of threshold and previous sum on a start threshold write
  typedef struct packed {
    logic             load;
    logic [LVL_W-1:0] level;
  } start_load_t;

endpackage

// ===== design/scdt_window.sv =====
// ----------------------------------------------------------------------------
// step counter sample window
// circular sample buffer with a running sum of the last taps
// ----------------------------------------------------------------------------
module scdt_window
  import scdt_pkg::*;
#(
  parameter int TAPS = 5,
  localparam int SUM_W = $clog2(MAG_MAX * TAPS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [MAG_W-1:0] magnitude,
  output logic [SUM_W-1:0] sum_next
);

  localparam int SLOT_W = $clog2(TAPS);

  logic [MAG_W-1:0]  taps [TAPS];
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  sum;

  // oldest sample leaves, new one enters
  assign sum_next = sum - SUM_W'(taps[slot]) + SUM_W'(magnitude);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      sum  <= '0;
      for (int i = 0; i < TAPS; i++) begin
        taps[i] <= '0;
      end
    end else if (en) begin
      taps[slot] <= magnitude;
      sum        <= sum_next;
      if (slot == SLOT_W'(TAPS - 1)) begin
        slot <= '0;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

endmodule

// ===== design/scdt_threshold.sv =====
// ----------------------------------------------------------------------------
// step counter threshold tracker
// window peak and trough, periodic threshold update
// ----------------------------------------------------------------------------
module scdt_threshold
  import scdt_pkg::*;
#(
  parameter int TAPS = 5,
  localparam int SUM_W = $clog2(MAG_MAX * TAPS + 1),
  localparam int THR_W = SUM_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cfg_t             cfg,
  input  start_load_t      start,
  input  logic [SUM_W-1:0] sum_in,
  output logic [THR_W-1:0] thr_next
);

  localparam logic [SUM_W-1:0] TROUGH_START = SUM_W'(TROUGH_BASE * TAPS);

  logic [SUM_W-1:0]  peak;
  logic [SUM_W-1:0]  trough;
  logic [WLEN_W-1:0] fill;
  logic [THR_W-1:0]  thr;

  logic [SUM_W-1:0]  peak_next;
  logic [SUM_W-1:0]  trough_next;
  logic [WLEN_W-1:0] fill_inc;
  logic              window_done;
  logic [SUM_W-1:0]  swing_min;
  logic              swing_ok;

  always_comb begin
    peak_next   = (sum_in > peak) ? sum_in : peak;
    trough_next = (sum_in < trough) ? sum_in : trough;
    fill_inc    = fill + 1'b1;
    window_done = (fill_inc >= cfg.window_length);
    swing_min   = SUM_W'(cfg.swing_limit) * SUM_W'(TAPS);
    swing_ok    = (peak_next > trough_next) &&
                  ((peak_next - trough_next) > swing_min);
    thr_next    = thr;
    if (window_done) begin
      if (swing_ok) begin
        thr_next = THR_W'(peak_next) + THR_W'(trough_next);
      end else begin
        thr_next = THR_W'(cfg.rest_threshold) * THR_W'(2 * TAPS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak   <= '0;
      trough <= TROUGH_START;
      fill   <= '0;
      thr    <= THR_W'(START_THRESHOLD_RST) * THR_W'(2 * TAPS);
    end else if (start.load) begin
      thr <= THR_W'(start.level) * THR_W'(2 * TAPS);
    end else if (en) begin
      thr <= thr_next;
      if (window_done) begin
        peak   <= '0;
        trough <= TROUGH_START;
        fill   <= '0;
      end else begin
        peak   <= peak_next;
        trough <= trough_next;
        fill   <= fill_inc;
      end
    end
  end

endmodule

// ===== design/scdt_detect.sv =====
// ----------------------------------------------------------------------------
// step counter step detector
// upward crossing test, step gap timing and step count
// ----------------------------------------------------------------------------
module scdt_detect
  import scdt_pkg::*;
#(
  parameter int TAPS = 5,
  localparam int SUM_W = $clog2(MAG_MAX * TAPS + 1),
  localparam int THR_W = SUM_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  cfg_t               cfg,
  input  start_load_t        start,
  input  logic [SUM_W-1:0]   sum_in,
  input  logic [THR_W-1:0]   thr_in,
  input  logic [TIME_W-1:0]  time_in,
  output logic               detected,
  output logic [COUNT_W-1:0] count_next
);

  logic [SUM_W-1:0]   prev_sum;
  logic [TIME_W-1:0]  last_time;
  logic [COUNT_W-1:0] count;

  logic               crossing;
  logic [TIME_W-1:0]  gap;

  always_comb begin
    crossing   = ((THR_W'(sum_in) << 1) > thr_in) &&
                 ((THR_W'(prev_sum) << 1) <= thr_in);
    gap        = time_in - last_time;
    detected   = crossing && (gap > TIME_W'(cfg.min_step_gap_us));
    count_next = detected ? count + 1'b1 : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sum  <= SUM_W'(START_THRESHOLD_RST) * SUM_W'(TAPS);
      last_time <= '0;
      count     <= '0;
    end else if (start.load) begin
      prev_sum <= SUM_W'(start.level) * SUM_W'(TAPS);
    end else if (en) begin
      prev_sum <= sum_in;
      count    <= count_next;
      if (detected) begin
        last_time <= time_in;
      end
    end
  end

endmodule

// ===== design/step_counter_dynamic_threshold.sv =====
// ----------------------------------------------------------------------------
// step counter with dynamic threshold
// Takes one request per cycle while results are taken, each carrying an
// acceleration magnitude and a wrapping microsecond timestamp, and returns
// one result per request: the step flag, the running step total, the exact
// sum of the last AVERAGE_TAPS magnitudes and the current threshold at
// twice that scale. A request passes an input register, combinational adds
// and compares, and a result register; while the result register is held,
// the input register holds too. The window sum is kept as a running sum so
// each sample costs one add and one subtract. The threshold follows the
// midpoint of the window peak and trough every window_length samples, or
// drops to rest_threshold when the swing is small. Registers are to be
// written by the user only while no request is in flight; the block itself
// does not enforce this. Writing start_threshold reloads the threshold and
// the previous sum at once.
// ----------------------------------------------------------------------------
`include "step_counter_dynamic_threshold_assert.svh"

module step_counter_dynamic_threshold
  import scdt_pkg::*;
#(
  parameter int AVERAGE_TAPS = 5
) (
  input  logic                  clk,
  input  logic                  rst,

  // sample stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // magnitude[15:0], time_us[47:16]

  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata,   // step_detected[0], step_total[32:1],
                                           // smoothed_sum[51:33],
                                           // threshold_level[71:52]

  // register writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W = $clog2(MAG_MAX * AVERAGE_TAPS + 1);
  localparam int THR_W = SUM_W + 1;

  // configuration registers
  cfg_t        cfg;
  start_load_t start;

  // input register
  logic              in_valid;
  logic [MAG_W-1:0]  in_mag;
  logic [TIME_W-1:0] in_time;

  // result register
  logic               out_valid;
  logic               out_det;
  logic [COUNT_W-1:0] out_total;
  logic [SUM_W-1:0]   out_sum;
  logic [THR_W-1:0]   out_thr;

  // datapath between the two
  logic               advance;
  logic               process;
  logic [SUM_W-1:0]   sum_next;
  logic [THR_W-1:0]   thr_next;
  logic               det;
  logic [COUNT_W-1:0] count_next;

  // result register frees up when empty or being taken
  assign advance  = !out_valid || m_tready;
  assign process  = in_valid && advance;
  assign s_tready = !in_valid || advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = {THR_OUT_W'(out_thr), SMOOTH_W'(out_sum), out_total, out_det};

  // start threshold write reloads threshold and previous sum
  assign start.load  = cfg_wr_en && (cfg_addr == REG_START_THRESHOLD);
  assign start.level = cfg_wdata[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length   <= WINDOW_LENGTH_RST;
      cfg.min_step_gap_us <= MIN_STEP_GAP_RST;
      cfg.swing_limit     <= SWING_LIMIT_RST;
      cfg.rest_threshold  <= REST_THRESHOLD_RST;
      cfg.start_threshold <= START_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_WINDOW_LENGTH:   cfg.window_length   <= cfg_wdata[WLEN_W-1:0];
        REG_MIN_STEP_GAP:    cfg.min_step_gap_us <= cfg_wdata[GAP_W-1:0];
        REG_SWING_LIMIT:     cfg.swing_limit     <= cfg_wdata[LVL_W-1:0];
        REG_REST_THRESHOLD:  cfg.rest_threshold  <= cfg_wdata[LVL_W-1:0];
        REG_START_THRESHOLD: cfg.start_threshold <= cfg_wdata[LVL_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mag  <= s_tdata[MAG_W-1:0];
      in_time <= s_tdata[MAG_W +: TIME_W];
    end
  end

  scdt_window #(
    .TAPS (AVERAGE_TAPS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (process),
    .magnitude (in_mag),
    .sum_next  (sum_next)
  );

  scdt_threshold #(
    .TAPS (AVERAGE_TAPS)
  ) u_threshold (
    .clk      (clk),
    .rst      (rst),
    .en       (process),
    .cfg      (cfg),
    .start    (start),
    .sum_in   (sum_next),
    .thr_next (thr_next)
  );

  // crossing test uses the threshold after this sample's window update
  scdt_detect #(
    .TAPS (AVERAGE_TAPS)
  ) u_detect (
    .clk        (clk),
    .rst        (rst),
    .en         (process),
    .cfg        (cfg),
    .start      (start),
    .sum_in     (sum_next),
    .thr_in     (thr_next),
    .time_in    (in_time),
    .detected   (det),
    .count_next (count_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_det   <= det;
      out_total <= count_next;
      out_sum   <= sum_next;
      out_thr   <= thr_next;
    end
  end

  // a processed request always lands in the result register
  `SCDT_ASSERT_NEXT(a_process_lands, clk, rst, process, out_valid,
    "processed request did not reach the result register")

  // a counted step must sit above the threshold
  `SCDT_ASSERT_IMPLY(a_step_above_thr, clk, rst, out_valid && out_det,
    (THR_W'(out_sum) << 1) > out_thr, "step flagged below threshold")

  // running sum never exceeds a full window of maximum samples
  `SCDT_ASSERT_IMPLY(a_sum_range, clk, rst, out_valid,
    out_sum <= SUM_W'(MAG_MAX * AVERAGE_TAPS), "running sum out of range")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step counter testbench
// Drives acceleration samples into the step counter and checks every
// result against a cycle-free predictor of the window sum, the threshold
// update and the step rule. A short directed run exercises extreme
// magnitudes and timestamp wrap. Walking-like sample streams then run
// under several register settings, extremes included, with random gaps
// and back-pressure on both streams. Random samples and a long output
// stall follow.
// ----------------------------------------------------------------------------
module tb;
  import scdt_pkg::*;

  localparam int TAPS         = 5;       // block default for AVERAGE_TAPS
  localparam int DRAIN_SLACK  = 8;       // path holds an input and a result register
  localparam int HOLD_CYCLES  = 300;     // long output stall
  localparam int PHASE_ITEMS  = 45;
  localparam int PHASE_COUNT  = 10;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;  // indexes with no register
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  // one step report, packed as on m_tdata (step_detected in bit 0)
  typedef struct packed {
    logic [THR_OUT_W-1:0] threshold_level;
    logic [SMOOTH_W-1:0]  smoothed_sum;
    logic [COUNT_W-1:0]   step_total;
    logic                 step_detected;
  } step_report_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata   = '0;   // magnitude[15:0], time_us[47:16]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [71:0]           m_tdata;          // step_detected[0], step_total[32:1],
                                           // smoothed_sum[51:33],
                                           // threshold_level[71:52]
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  step_counter_dynamic_threshold DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor state: shadow registers and the counter's own state
  // --------------------------------------------------------------------------
  cfg_t                 shadow_regs;
  logic [MAG_W-1:0]     taps [TAPS];
  logic [2:0]           tap_slot;
  logic [SMOOTH_W-1:0]  window_peak;
  logic [SMOOTH_W-1:0]  window_trough;
  logic [WLEN_W-1:0]    window_fill;
  logic [THR_OUT_W-1:0] threshold_scaled;
  logic [SMOOTH_W-1:0]  previous_sum;
  logic [TIME_W-1:0]    prior_step_stamp;
  logic [COUNT_W-1:0]   steps_counted;

  step_report_t step_reports_due [$];   // predicted reports, oldest first

  // idling and stall control
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  // run statistics
  int mismatches      = 0;
  int samples_sent    = 0;
  int reports_checked = 0;
  int steps_seen      = 0;
  int settings_used   = 0;
  int stall_refusals  = 0;

  step_report_t seen_report;
  step_report_t due_report;

  task automatic reset_step_model();
    shadow_regs.window_length   = WINDOW_LENGTH_RST;
    shadow_regs.min_step_gap_us = MIN_STEP_GAP_RST;
    shadow_regs.swing_limit     = SWING_LIMIT_RST;
    shadow_regs.rest_threshold  = REST_THRESHOLD_RST;
    shadow_regs.start_threshold = START_THRESHOLD_RST;
    for (int k = 0; k < TAPS; k++) taps[k] = '0;
    tap_slot         = '0;
    window_peak      = '0;
    window_trough    = SMOOTH_W'(TROUGH_BASE * TAPS);
    window_fill      = '0;
    prior_step_stamp = '0;
    steps_counted    = '0;
    threshold_scaled = THR_OUT_W'(START_THRESHOLD_RST * 2 * TAPS);
    previous_sum     = SMOOTH_W'(START_THRESHOLD_RST * TAPS);
  endtask

  // advances the counter by one sample and returns the report it produces
  function automatic step_report_t count_step_sample(input logic [MAG_W-1:0] mag,
                                                     input logic [TIME_W-1:0] stamp);
    logic [SMOOTH_W-1:0] sum;
    logic [TIME_W-1:0]   since_step;
    step_report_t        r;
    taps[tap_slot] = mag;
    tap_slot = (tap_slot == TAPS - 1) ? 3'd0 : tap_slot + 3'd1;
    sum = '0;
    for (int k = 0; k < TAPS; k++) sum += SMOOTH_W'(taps[k]);

    if (sum > window_peak)   window_peak   = sum;
    if (sum < window_trough) window_trough = sum;

    // window end: midpoint if the swing is wide enough, else the rest level;
    // a window length of zero behaves as one
    window_fill = window_fill + 1'b1;
    if (window_fill >= shadow_regs.window_length) begin
      if (window_peak > window_trough &&
          (window_peak - window_trough) > shadow_regs.swing_limit * TAPS)
        threshold_scaled = THR_OUT_W'(window_peak) + THR_OUT_W'(window_trough);
      else
        threshold_scaled = THR_OUT_W'(shadow_regs.rest_threshold * 2 * TAPS);
      window_peak   = '0;
      window_trough = SMOOTH_W'(TROUGH_BASE * TAPS);
      window_fill   = '0;
    end

    // upward crossing, gated by the wrapping time since the last step
    r.step_detected = 1'b0;
    if (2 * sum > threshold_scaled && 2 * previous_sum <= threshold_scaled) begin
      since_step = stamp - prior_step_stamp;
      if (since_step > shadow_regs.min_step_gap_us) begin
        steps_counted    = steps_counted + 1'b1;
        prior_step_stamp = stamp;
        r.step_detected  = 1'b1;
      end
    end
    previous_sum = sum;

    r.step_total      = steps_counted;
    r.smoothed_sum    = sum;
    r.threshold_level = threshold_scaled;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // offers one request and waits for the handshake; valid stays high after
  // acceptance so back-to-back requests need no extra edge
  task automatic send_sample(input logic [MAG_W-1:0] mag, input logic [TIME_W-1:0] stamp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stamp, mag};
    do begin
      @(posedge clk);
      if (!s_tready) stall_refusals++;
    end while (!s_tready);
    step_reports_due.push_back(count_step_sample(mag, stamp));
    samples_sent++;
  endtask

  // lets every predicted report arrive, then waits out DRAIN_SLACK
  task automatic wait_reports_drained();
    s_tvalid <= 1'b0;
    while (step_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // one register write; enable is lowered only after the last of a burst
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_WINDOW_LENGTH:   shadow_regs.window_length   = data[WLEN_W-1:0];
      REG_MIN_STEP_GAP:    shadow_regs.min_step_gap_us = data[GAP_W-1:0];
      REG_SWING_LIMIT:     shadow_regs.swing_limit     = data[LVL_W-1:0];
      REG_REST_THRESHOLD:  shadow_regs.rest_threshold  = data[LVL_W-1:0];
      REG_START_THRESHOLD: begin
        // a start level write reloads the threshold and the previous sum
        shadow_regs.start_threshold = data[LVL_W-1:0];
        threshold_scaled = THR_OUT_W'(data[LVL_W-1:0] * 2 * TAPS);
        previous_sum     = SMOOTH_W'(data[LVL_W-1:0] * TAPS);
      end
      default: ;
    endcase
    if (last) cfg_wr_en <= 1'b0;
  endtask

  // picks one register setting: all minimums, all maximums, a one-sample
  // window, then random mixes with the extremes mixed in
  task automatic program_settings(input int phase);
    logic [CFG_DATA_W-1:0] wl, gap, swing, rest, start;
    int pick;
    wl    = CFG_DATA_W'($urandom);
    gap   = CFG_DATA_W'($urandom);
    swing = CFG_DATA_W'($urandom);
    rest  = CFG_DATA_W'($urandom);
    start = CFG_DATA_W'($urandom);
    case (phase)
      0: begin
        wl[WLEN_W-1:0] = '0; gap = '0; swing[LVL_W-1:0] = '0;
        rest[LVL_W-1:0] = '0; start[LVL_W-1:0] = '0;
      end
      1: begin
        wl[WLEN_W-1:0] = '1; gap = '1; swing[LVL_W-1:0] = '1;
        rest[LVL_W-1:0] = '1; start[LVL_W-1:0] = '1;
      end
      default: begin
        pick = $urandom_range(5);
        wl[WLEN_W-1:0] = (phase == 2) ? 10'd1 : (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 :
                         10'($urandom_range(80, 2));
        pick = $urandom_range(5);
        gap = (pick == 0) ? '0 : (pick == 1) ? '1 : 24'($urandom_range(300000));
        pick = $urandom_range(5);
        swing[LVL_W-1:0] = (pick == 0) ? '0 : (pick == 1) ? '1 : 16'($urandom_range(6000));
        pick = $urandom_range(5);
        rest[LVL_W-1:0]  = (pick == 0) ? '0 : (pick == 1) ? '1 : 16'($urandom);
        pick = $urandom_range(5);
        start[LVL_W-1:0] = (pick == 0) ? '0 : (pick == 1) ? '1 : 16'($urandom);
      end
    endcase
    write_reg(REG_WINDOW_LENGTH, wl, 1'b0);
    write_reg(REG_MIN_STEP_GAP, gap, 1'b0);
    write_reg(REG_SWING_LIMIT, swing, 1'b0);
    write_reg(REG_REST_THRESHOLD, rest, 1'b0);
    // a write to an index with no register must change nothing
    write_reg(CFG_ADDR_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
              CFG_DATA_W'($urandom), 1'b0);
    write_reg(REG_START_THRESHOLD, start, 1'b1);
    settings_used++;
  endtask

  // walking-like stream: a triangle wave around a random baseline with
  // jitter, timestamps advancing by a cadence; noise_pct of the requests are
  // fully random instead
  task automatic run_walk(input int n_items, input int noise_pct);
    int base, swing, period, cadence, pos, level, jitter;
    logic [TIME_W-1:0] stamp;
    logic [MAG_W-1:0]  mag;
    base    = $urandom_range(40000, 2000);
    swing   = $urandom_range(30000);
    period  = $urandom_range(40, 4);
    cadence = $urandom_range(80000, 1000);
    stamp   = $urandom;
    for (int i = 0; i < n_items; i++) begin
      stamp = stamp + TIME_W'(cadence) + TIME_W'($urandom_range(cadence / 8));
      if ($urandom_range(99) < noise_pct) begin
        mag = ($urandom_range(9) == 0) ? '1 : ($urandom_range(9) == 0) ? '0 : MAG_W'($urandom);
        send_sample(mag, ($urandom_range(3) == 0) ? TIME_W'($urandom) : stamp);
      end else begin
        pos    = i % period;
        jitter = $urandom_range(400);
        level  = base - swing / 2 + (2 * swing * ((pos < period / 2) ? pos : period - pos)) / period
                 + jitter - 200;
        if (level < 0)       level = 0;
        if (level > MAG_MAX) level = MAG_MAX;
        send_sample(MAG_W'(level), stamp);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset settings: full-scale and zero magnitudes, a step far from the
  // last one, a crossing exactly one gap after the last step (not counted)
  // and one just past it, both across the timestamp wrap
  task automatic test_default_steps();
    send_sample(16'h0000, 32'h0000_0000);
    send_sample(16'hFFFF, 32'd1000);
    send_sample(16'hFFFF, 32'd2000);
    send_sample(16'hFFFF, 32'hFFFF_FFFF);   // first crossing
    send_sample(16'hFFFF, 32'h0000_0010);   // still above, no crossing
    for (int i = 0; i < 5; i++) send_sample(16'h0000, 32'd100 + i);
    send_sample(16'hFFFF, 32'd200000);
    send_sample(16'hFFFF, 32'd400000);
    send_sample(16'hFFFF, 32'd599999);      // gap equals the minimum, no step
    for (int i = 0; i < 5; i++) send_sample(16'h0000, 32'd599999);
    send_sample(16'hFFFF, 32'd599999);
    send_sample(16'hFFFF, 32'd599999);
    send_sample(16'hFFFF, 32'd600000);      // one microsecond past, counted
    wait_reports_drained();
  endtask

  // walking streams under changing register settings and idling modes
  task automatic test_register_settings();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 4)      set_idling(31, 87);
      else if (p < 8) set_idling(87, 31);
      else            set_idling(0, 0);
      program_settings(p);
      run_walk(PHASE_ITEMS, 10);
      wait_reports_drained();
    end
  endtask

  // unstructured samples and timestamps
  task automatic test_noise_items();
    set_idling(0, 0);
    program_settings(PHASE_COUNT);
    run_walk(40, 100);
    wait_reports_drained();
  endtask

  // receiver holds off for a long stretch while samples keep coming, so the
  // block fills and refuses input
  task automatic test_output_stall();
    set_idling(0, 0);
    program_settings(PHASE_COUNT + 1);
    holds_asked++;
    run_walk(40, 10);
    wait_reports_drained();
  endtask

  // --------------------------------------------------------------------------
  // result side: ready pattern and the long stall, counted here
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_report = m_tdata;
      if (step_reports_due.size() == 0) begin
        $error("result with no request pending: %h", m_tdata);
        mismatches++;
      end else begin
        due_report = step_reports_due.pop_front();
        check_field("step_detected", due_report.step_detected, seen_report.step_detected);
        check_field("step_total", due_report.step_total, seen_report.step_total);
        check_field("smoothed_sum", due_report.smoothed_sum, seen_report.smoothed_sum);
        check_field("threshold_level", due_report.threshold_level, seen_report.threshold_level);
        reports_checked++;
        if (seen_report.step_detected) steps_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_step_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(31, 87);
    test_default_steps();
    test_register_settings();
    test_noise_items();
    test_output_stall();

    if (step_reports_due.size() != 0) begin
      $error("%0d predicted results never arrived", step_reports_due.size());
      mismatches++;
    end
    $display("summary: %0d samples, %0d results checked, %0d steps, %0d register settings",
             samples_sent, reports_checked, steps_seen, settings_used);
    $display("summary: %0d input refusals seen, %0d long output stall(s)",
             stall_refusals, holds_served);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // hang guard, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/scdt_pkg.sv
design/scdt_window.sv
design/scdt_threshold.sv
design/scdt_detect.sv
design/step_counter_dynamic_threshold.sv
tb/tb.sv
